>>> rtl/delta_patch_applier_top_macros.svh
// ----------------------------------------------------------------------------
// Delta patch applier assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DELTA_PATCH_APPLIER_TOP_MACROS_SVH
`define DELTA_PATCH_APPLIER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// check while out of reset
`define DPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also covers reset itself
`define DPA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPA_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/dpa_pkg.sv
// ----------------------------------------------------------------------------
// Delta patch applier package
// Phase and status codes, register indexes and item/result types.
// ----------------------------------------------------------------------------
package dpa_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_SIZE,
    PH_ENTRY,
    PH_DIFF,
    PH_EXTRA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY,
    ST_OK,
    ST_BAD_MAGIC,
    ST_SIZE_MISMATCH,
    ST_EARLY_END,
    ST_RANGE_ERR
  } status_t;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD,
    CFG_OLD_IMAGE_SIZE
  } cfg_idx_t;

  localparam int CFG_DATA_W = 64;
  localparam int OLD_SIZE_W = 32;
  localparam int OLD_ADDR_W = 32;

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       patch_end;
    logic [7:0] old_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]            new_byte;
    logic                  new_valid;
    logic [OLD_ADDR_W-1:0] old_address;
    logic [2:0]            status;
  } result_t;

endpackage

>>> rtl/dpa_core.sv
// ----------------------------------------------------------------------------
// Delta patch applier core
// Patch state registers and the single-pass update for one patch byte.
// ----------------------------------------------------------------------------
module dpa_core #(
  parameter int OLD_ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  dpa_pkg::item_t                      item,
  input  logic [dpa_pkg::CFG_DATA_W-1:0]      magic_word,
  input  logic [dpa_pkg::OLD_SIZE_W-1:0]      old_image_size,
  output dpa_pkg::result_t                    res
);

  localparam int POS_W = OLD_ADDR_BITS + 1;
  localparam logic [63:0] ADDR_SPACE = 64'd1 << OLD_ADDR_BITS;

  dpa_pkg::phase_t  phase_r, phase_nxt;
  dpa_pkg::status_t status_r, status_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [63:0]      shift_r, shift_nxt;
  logic [63:0]      exp_size_r, exp_size_nxt;
  logic [63:0]      diff_r, diff_nxt;
  logic [63:0]      extra_r, extra_nxt;
  logic [63:0]      seek_r, seek_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0]      written_r, written_nxt;

  logic [63:0]      shifted;
  logic [4:0]       cnt_inc;
  logic             byte8, byte16, byte24;
  logic             all_zero;
  logic [63:0]      size64, lim64;
  logic [POS_W-1:0] lim;
  logic [POS_W-1:0] pos_inc;
  logic             diff_err, diff_last, extra_last;
  logic [63:0]      seg_seek;
  logic [POS_W-1:0] seg_pos;
  logic [64:0]      seek_sum;
  logic             seg_diff_nz, seg_extra_nz, seek_err;
  logic             seg_fail, seg_apply;
  dpa_pkg::phase_t  seg_phase;
  logic [7:0]       nb;
  logic             nv;
  logic [63:0]      pos64;

  assign shifted  = {shift_r[55:0], item.patch_byte};
  assign cnt_inc  = cnt_r + 5'd1;
  assign byte8    = (cnt_inc == 5'd8);
  assign byte16   = (cnt_inc == 5'd16);
  assign byte24   = (cnt_inc == 5'd24);
  assign all_zero = (diff_r == 64'd0) && (extra_r == 64'd0) && (shifted == 64'd0);

  // old image limit: configured size, capped by the address space
  assign size64 = 64'(old_image_size);
  assign lim64  = (size64 < ADDR_SPACE) ? size64 : ADDR_SPACE;
  assign lim    = lim64[POS_W-1:0];

  assign pos_inc    = pos_r + POS_W'(1);
  assign diff_err   = (pos_r >= lim);
  assign diff_last  = (diff_r == 64'd1);
  assign extra_last = (extra_r == 64'd1);

  // segment advance: diff, then extra, then apply the relative seek
  assign seg_diff_nz  = (phase_r == dpa_pkg::PH_ENTRY) && (diff_r != 64'd0);
  assign seg_extra_nz = ((phase_r == dpa_pkg::PH_ENTRY) || (phase_r == dpa_pkg::PH_DIFF))
                        && (extra_r != 64'd0);
  assign seg_seek = (phase_r == dpa_pkg::PH_ENTRY) ? shifted : seek_r;
  assign seg_pos  = (phase_r == dpa_pkg::PH_DIFF) ? pos_inc : pos_r;
  assign seek_sum = {seg_seek[63], seg_seek} + 65'(seg_pos);
  assign seek_err = (seg_pos > lim) || seek_sum[64] || (seek_sum[63:0] > lim64);

  assign seg_fail  = !seg_diff_nz && !seg_extra_nz && seek_err;
  assign seg_apply = !seg_diff_nz && !seg_extra_nz && !seek_err;
  assign seg_phase = seg_diff_nz  ? dpa_pkg::PH_DIFF  :
                     seg_extra_nz ? dpa_pkg::PH_EXTRA :
                     seek_err     ? dpa_pkg::PH_DONE  : dpa_pkg::PH_ENTRY;

  // next phase and final status
  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    if (phase_r != dpa_pkg::PH_DONE) begin
      if (item.patch_end) begin
        phase_nxt  = dpa_pkg::PH_DONE;
        status_nxt = dpa_pkg::ST_EARLY_END;
      end else begin
        case (phase_r)
          dpa_pkg::PH_MAGIC: begin
            if (byte8) begin
              if (shifted != magic_word) begin
                phase_nxt  = dpa_pkg::PH_DONE;
                status_nxt = dpa_pkg::ST_BAD_MAGIC;
              end else begin
                phase_nxt = dpa_pkg::PH_SIZE;
              end
            end
          end
          dpa_pkg::PH_SIZE: begin
            if (byte8) begin
              phase_nxt = dpa_pkg::PH_ENTRY;
            end
          end
          dpa_pkg::PH_ENTRY: begin
            if (byte24) begin
              if (all_zero) begin
                phase_nxt  = dpa_pkg::PH_DONE;
                status_nxt = (written_r == exp_size_r) ? dpa_pkg::ST_OK
                                                       : dpa_pkg::ST_SIZE_MISMATCH;
              end else begin
                phase_nxt = seg_phase;
                if (seg_fail) begin
                  status_nxt = dpa_pkg::ST_RANGE_ERR;
                end
              end
            end
          end
          dpa_pkg::PH_DIFF: begin
            if (diff_err) begin
              phase_nxt  = dpa_pkg::PH_DONE;
              status_nxt = dpa_pkg::ST_RANGE_ERR;
            end else if (diff_last) begin
              phase_nxt = seg_phase;
              if (seg_fail) begin
                status_nxt = dpa_pkg::ST_RANGE_ERR;
              end
            end
          end
          dpa_pkg::PH_EXTRA: begin
            if (extra_last) begin
              phase_nxt = seg_phase;
              if (seg_fail) begin
                status_nxt = dpa_pkg::ST_RANGE_ERR;
              end
            end
          end
          default: begin
            phase_nxt  = dpa_pkg::PH_DONE;
            status_nxt = dpa_pkg::ST_EARLY_END;
          end
        endcase
      end
    end
  end

  // field assembly, counters, old position and output byte
  always_comb begin
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    exp_size_nxt = exp_size_r;
    diff_nxt     = diff_r;
    extra_nxt    = extra_r;
    seek_nxt     = seek_r;
    pos_nxt      = pos_r;
    written_nxt  = written_r;
    nb           = 8'd0;
    nv           = 1'b0;
    if ((phase_r != dpa_pkg::PH_DONE) && !item.patch_end) begin
      case (phase_r)
        dpa_pkg::PH_MAGIC, dpa_pkg::PH_SIZE: begin
          shift_nxt = shifted;
          cnt_nxt   = cnt_inc;
          if (byte8) begin
            shift_nxt = 64'd0;
            cnt_nxt   = 5'd0;
            if (phase_r == dpa_pkg::PH_SIZE) begin
              exp_size_nxt = shifted;
            end
          end
        end
        dpa_pkg::PH_ENTRY: begin
          shift_nxt = shifted;
          cnt_nxt   = cnt_inc;
          if (byte8) begin
            diff_nxt = shifted;
          end
          if (byte16) begin
            extra_nxt = shifted;
          end
          if (byte24) begin
            seek_nxt  = shifted;
            shift_nxt = 64'd0;
            cnt_nxt   = 5'd0;
            if (!all_zero && seg_apply) begin
              pos_nxt = seek_sum[POS_W-1:0];
            end
          end
        end
        dpa_pkg::PH_DIFF: begin
          if (!diff_err) begin
            nb          = item.old_byte + item.patch_byte;
            nv          = 1'b1;
            pos_nxt     = pos_inc;
            written_nxt = written_r + 64'd1;
            diff_nxt    = diff_r - 64'd1;
            if (diff_last && seg_apply) begin
              pos_nxt = seek_sum[POS_W-1:0];
            end
          end
        end
        dpa_pkg::PH_EXTRA: begin
          nb          = item.patch_byte;
          nv          = 1'b1;
          written_nxt = written_r + 64'd1;
          extra_nxt   = extra_r - 64'd1;
          if (extra_last && seg_apply) begin
            pos_nxt = seek_sum[POS_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dpa_pkg::PH_MAGIC;
      status_r   <= dpa_pkg::ST_BUSY;
      cnt_r      <= 5'd0;
      shift_r    <= 64'd0;
      exp_size_r <= 64'd0;
      diff_r     <= 64'd0;
      extra_r    <= 64'd0;
      seek_r     <= 64'd0;
      pos_r      <= '0;
      written_r  <= 64'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      status_r   <= status_nxt;
      cnt_r      <= cnt_nxt;
      shift_r    <= shift_nxt;
      exp_size_r <= exp_size_nxt;
      diff_r     <= diff_nxt;
      extra_r    <= extra_nxt;
      seek_r     <= seek_nxt;
      pos_r      <= pos_nxt;
      written_r  <= written_nxt;
    end
  end

  assign pos64           = 64'(pos_nxt);
  assign res.new_byte    = nb;
  assign res.new_valid   = nv;
  assign res.old_address = pos64[dpa_pkg::OLD_ADDR_W-1:0];
  assign res.status      = status_nxt;

endmodule

>>> rtl/delta_patch_applier_top.sv
// ----------------------------------------------------------------------------
// Delta patch applier top level
// Input register, patch core, result register and configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Program magic_word (index 0) and old_image_size (index 1) on the cfg_
//   port while idle; cfg_ready is always high. Then stream the patch one byte
//   per in_ transfer. With each byte, supply in_old_byte read from the old
//   image at the out_old_address of the previous result (address 0 at first).
//   Every input transfer yields exactly one result transfer with new_byte,
//   new_valid, old_address and status (0 while busy, then the final code).
//   Each byte passes the input register, the core and the result register.
//   Throughput: one byte per cycle unless out_stall holds the result; the core
//   updates every patch counter and the old position in a single pass
//   between the input and result registers.
//   The input register doubles as a skid stage: in_stall rises only when it
//   is full and the result register is held by out_stall.
//   Reset clears the pipeline, the patch state and both configuration
//   registers; the next stream starts with the magic bytes.
// ----------------------------------------------------------------------------
`include "delta_patch_applier_top_macros.svh"

module delta_patch_applier_top #(
  parameter int OLD_ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_patch_byte,
  input  logic                                in_patch_end,
  input  logic [7:0]                          in_old_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_new_byte,
  output logic                                out_new_valid,
  output logic [dpa_pkg::OLD_ADDR_W-1:0]      out_old_address,
  output logic [2:0]                          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                               in_valid_r, in_valid_nxt;
  dpa_pkg::item_t                     item_r;
  logic                               out_valid_r, out_valid_nxt;
  dpa_pkg::result_t                   res_r;
  dpa_pkg::result_t                   core_res;
  logic [dpa_pkg::CFG_DATA_W-1:0]     magic_r;
  logic [dpa_pkg::OLD_SIZE_W-1:0]     old_size_r;
  logic                               out_free;
  logic                               adv;
  logic                               in_take;
  logic                               cfg_wr;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.patch_byte <= in_patch_byte;
      item_r.patch_end  <= in_patch_end;
      item_r.old_byte   <= in_old_byte;
    end
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      old_size_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == dpa_pkg::CFG_MAGIC_WORD) begin
        magic_r <= cfg_data;
      end
      if (cfg_index == dpa_pkg::CFG_OLD_IMAGE_SIZE) begin
        old_size_r <= cfg_data[dpa_pkg::OLD_SIZE_W-1:0];
      end
    end
  end

  dpa_core #(
    .OLD_ADDR_BITS(OLD_ADDR_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .item          (item_r),
    .magic_word    (magic_r),
    .old_image_size(old_size_r),
    .res           (core_res)
  );

  assign out_valid       = out_valid_r;
  assign out_new_byte    = res_r.new_byte;
  assign out_new_valid   = res_r.new_valid;
  assign out_old_address = res_r.old_address;
  assign out_status      = res_r.status;

  `DPA_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid_r,
                  "result valid after reset")
  `DPA_ASSERT(a_result_from_item, clk, rst_n,
              $rose(out_valid_r) |-> $past(in_valid_r),
              "result without a held item")
  // a byte may still go out with the range error raised by the seek after it
  `DPA_ASSERT(a_byte_status, clk, rst_n,
              (out_valid_r && res_r.new_valid) |->
              (res_r.status == dpa_pkg::ST_BUSY || res_r.status == dpa_pkg::ST_RANGE_ERR),
              "output byte with an unexpected final status")
  `DPA_ASSERT(a_final_sticks, clk, rst_n,
              (adv && res_r.status != dpa_pkg::ST_BUSY) |=>
              (res_r.status == $past(res_r.status)),
              "final status changed")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Delta patch applier testbench
// Streams one bspatch-style patch through the block: magic, new size, a run
// of well-formed entries with random content and seeks, then one way of
// ending it, then bytes after the end. Every result is checked against a
// byte-level model of the applier kept in the testbench. The old image size,
// and now and then the magic, are rewritten between batches while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dpa_pkg::*;

  localparam int ITEMS = 1300;

  typedef enum {
    END_OK,
    END_SIZE_MISMATCH,
    END_CUT_HEADER,
    END_CUT_EXTRA,
    END_DIFF_RANGE,
    END_SEEK_RANGE,
    END_POS_PAST_SIZE
  } ending_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_patch_byte = 8'h00;
  logic                  in_patch_end = 1'b0;
  logic [7:0]            in_old_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_new_byte;
  logic                  out_new_valid;
  logic [OLD_ADDR_W-1:0] out_old_address;
  logic [2:0]            out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  delta_patch_applier_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_patch_byte   (in_patch_byte),
    .in_patch_end    (in_patch_end),
    .in_old_byte     (in_old_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_byte    (out_new_byte),
    .out_new_valid   (out_new_valid),
    .out_old_address (out_old_address),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  item_t   patch_q[$];
  result_t expected_new_image[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  wire     calm = (cycle_count >= 600) && (cycle_count < 1000);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // --------------------------------------------------------------------------
  // Applier model: register copies and patch state
  // --------------------------------------------------------------------------
  logic [63:0] cfg_magic = '0;
  logic [63:0] cfg_old_size = '0;
  phase_t      pst_phase = PH_MAGIC;
  logic [4:0]  hdr_count = '0;
  logic [63:0] hdr_shift = '0;
  logic [63:0] target_size = '0;
  logic [63:0] diff_rem = '0;
  logic [63:0] extra_rem = '0;
  logic [63:0] seek_val = '0;
  logic [63:0] old_pos = '0;
  logic [63:0] emit_count = '0;
  status_t     end_code = ST_BUSY;

  function automatic logic [63:0] old_span_limit();
    logic [63:0] span;
    span = 64'd1 << OLD_ADDR_W;
    return (cfg_old_size < span) ? cfg_old_size : span;
  endfunction

  task automatic close_stream(input status_t code);
    end_code = code;
    pst_phase = PH_DONE;
  endtask

  task automatic start_header();
    pst_phase = PH_ENTRY;
    hdr_count = '0;
    hdr_shift = '0;
  endtask

  // after an entry header or a segment runs out: go on to diff or extra bytes, or apply the seek
  task automatic enter_next_segment();
    logic [63:0] lim;
    logic [63:0] mag;
    lim = old_span_limit();
    if (diff_rem != 0) begin
      pst_phase = PH_DIFF;
    end else if (extra_rem != 0) begin
      pst_phase = PH_EXTRA;
    end else if (old_pos > lim) begin
      close_stream(ST_RANGE_ERR);
    end else if (seek_val[63]) begin
      mag = -seek_val;
      if (mag > old_pos) begin
        close_stream(ST_RANGE_ERR);
      end else begin
        old_pos = old_pos - mag;
        start_header();
      end
    end else if (seek_val > lim - old_pos) begin
      close_stream(ST_RANGE_ERR);
    end else begin
      old_pos = old_pos + seek_val;
      start_header();
    end
  endtask

  task automatic apply_patch_step(input item_t it);
    result_t r;
    r = '0;
    if (pst_phase != PH_DONE) begin
      if (it.patch_end) begin
        close_stream(ST_EARLY_END);
      end else begin
        case (pst_phase)
          PH_MAGIC, PH_SIZE, PH_ENTRY: begin
            hdr_shift = {hdr_shift[55:0], it.patch_byte};
            hdr_count = hdr_count + 5'd1;
            if (pst_phase == PH_MAGIC) begin
              if (hdr_count == 8) begin
                if (hdr_shift != cfg_magic) begin
                  close_stream(ST_BAD_MAGIC);
                end else begin
                  pst_phase = PH_SIZE;
                  hdr_count = '0;
                  hdr_shift = '0;
                end
              end
            end else if (pst_phase == PH_SIZE) begin
              if (hdr_count == 8) begin
                target_size = hdr_shift;
                start_header();
              end
            end else if (hdr_count == 8) begin
              diff_rem = hdr_shift;
            end else if (hdr_count == 16) begin
              extra_rem = hdr_shift;
            end else if (hdr_count == 24) begin
              seek_val = hdr_shift;
              hdr_count = '0;
              hdr_shift = '0;
              if (diff_rem == 0 && extra_rem == 0 && seek_val == 0) begin
                close_stream((emit_count == target_size) ? ST_OK : ST_SIZE_MISMATCH);
              end else begin
                enter_next_segment();
              end
            end
          end
          PH_DIFF: begin
            if (old_pos >= old_span_limit()) begin
              close_stream(ST_RANGE_ERR);
            end else begin
              r.new_byte = it.old_byte + it.patch_byte;
              r.new_valid = 1'b1;
              old_pos = old_pos + 1;
              emit_count = emit_count + 1;
              diff_rem = diff_rem - 1;
              if (diff_rem == 0) enter_next_segment();
            end
          end
          PH_EXTRA: begin
            r.new_byte = it.patch_byte;
            r.new_valid = 1'b1;
            emit_count = emit_count + 1;
            extra_rem = extra_rem - 1;
            if (extra_rem == 0) enter_next_segment();
          end
          default: begin
            close_stream(ST_EARLY_END);
          end
        endcase
      end
    end
    r.old_address = old_pos[OLD_ADDR_W-1:0];
    r.status = end_code;
    expected_new_image.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Patch byte driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_patch_step({in_patch_byte, in_patch_end, in_old_byte});
      end
      // hold a stalled transfer, otherwise offer the next byte or idle
      if (!in_valid || !in_stall) begin
        if (patch_q.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
          nxt = patch_q.pop_front();
          in_patch_byte <= nxt.patch_byte;
          in_patch_end <= nxt.patch_end;
          in_old_byte <= nxt.old_byte;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  int results_seen = 0;
  int hold_left = 0;
  int holdoffs = 0;

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_new_image.size() == 0) begin
          $display("%0t ns: result with none expected, actual byte %0h status %0d",
                   $time, out_new_byte, out_status);
          mismatches++;
        end else begin
          want = expected_new_image.pop_front();
          check_field("new_byte", want.new_byte, out_new_byte);
          check_field("new_valid", want.new_valid, out_new_valid);
          check_field("old_address", want.old_address, out_old_address);
          check_field("status", want.status, out_status);
        end
      end
      // long hold-off while the driver keeps offering, so the block backs up
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holdoffs < 2 && results_seen >= 150 + 500 * holdoffs &&
                   patch_q.size() > 40) begin
        out_stall <= 1'b1;
        hold_left = 60;
        holdoffs++;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 17);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Patch stream generation
  // --------------------------------------------------------------------------
  longint g_pos = 0;
  longint g_size = 0;

  task automatic queue_item(input logic [7:0] pb, input logic pe, input logic [7:0] ob);
    patch_q.push_back({pb, pe, ob});
  endtask

  task automatic queue_byte(input logic [7:0] pb);
    logic [7:0] ob;
    ob = $urandom_range(0, 255);
    queue_item(pb, 1'b0, ob);
  endtask

  task automatic queue_word(input logic [63:0] v);
    for (int i = 7; i >= 0; i--) queue_byte(v[i*8 +: 8]);
  endtask

  // one entry writing total bytes; reads stay inside the old image
  task automatic queue_entry(input int unsigned total);
    longint d;
    longint e;
    longint s;
    longint at;
    longint lo;
    longint hi;
    int unsigned k;
    if (total == 0) begin
      d = 0;
      e = 0;
      s = (g_pos != 0) ? -g_pos : g_size;
    end else begin
      d = (g_size - g_pos < total) ? g_size - g_pos : total;
      d = $urandom_range(0, int'(d));
      e = total - d;
      at = g_pos + d;
      k = $urandom_range(0, 7);
      if (k == 0) begin
        s = -at;
      end else if (k == 1) begin
        s = g_size - at;
      end else if (k == 2) begin
        s = 0;
      end else begin
        lo = (at < 100) ? -at : -100;
        hi = (g_size - at < 100) ? g_size - at : 100;
        s = lo + longint'($urandom_range(0, int'(hi - lo)));
      end
    end
    queue_word(d);
    queue_word(e);
    queue_word(s);
    repeat (d) queue_byte($urandom_range(0, 255));
    repeat (e) queue_byte($urandom_range(0, 255));
    g_pos = g_pos + d + s;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (patch_q.size() != 0 || in_valid || expected_new_image.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAGIC_WORD) cfg_magic = v;
    else cfg_old_size = {32'd0, v[31:0]};
  endtask

  initial begin : stimulus
    int unsigned plan[$];
    int unsigned len;
    int unsigned n;
    int unsigned k;
    longint budget;
    longint nsz;
    logic [63:0] total_out;
    logic [63:0] magic_val;
    logic [63:0] seek;
    ending_t ending;
    bit bad_magic;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    ending = ending_t'($urandom_range(0, 6));
    bad_magic = ($urandom_range(0, 15) == 0);
    magic_val = {$urandom, $urandom};

    // new size has to be known up front, so lay out the entry lengths first
    total_out = 3;
    budget = 43;
    while (budget < ITEMS) begin
      len = $urandom_range(1, 40);
      plan.push_back(len);
      total_out += len;
      budget += 24 + len;
    end
    if (ending == END_SIZE_MISMATCH) total_out ^= {$urandom, $urandom} | 64'd1;

    cfg_write(CFG_MAGIC_WORD, '1);
    cfg_write(CFG_OLD_IMAGE_SIZE, '0);
    cfg_write(CFG_MAGIC_WORD, '0);
    cfg_write(CFG_MAGIC_WORD, magic_val);
    cfg_write(CFG_OLD_IMAGE_SIZE, {$urandom, 32'hFFFF_FFFF});
    g_size = 64'hFFFF_FFFF;

    queue_word(bad_magic ? magic_val ^ (64'd1 << $urandom_range(0, 63)) : magic_val);
    queue_word(total_out);
    // opening entry: diff sums that wrap and stay at zero, one extra byte, seek -1
    queue_word(64'd2);
    queue_word(64'd1);
    queue_word('1);
    queue_item(8'hFF, 1'b0, 8'hFF);
    queue_item(8'h00, 1'b0, 8'h00);
    queue_byte(8'hFF);
    g_pos = 1;

    do begin
      n = $urandom_range(4, 10);
      while (n != 0 && plan.size() != 0) begin
        if (g_size != 0 && $urandom_range(0, 9) == 0) queue_entry(0);
        queue_entry(plan.pop_front());
        n--;
      end
      wait_drained();
      k = $urandom_range(0, 3);
      if (k == 0) nsz = 64'hFFFF_FFFF;
      else if (k == 1) nsz = g_pos;
      else nsz = g_pos + $urandom_range(0, 300);
      if (plan.size() == 0) begin
        if (ending == END_POS_PAST_SIZE && g_pos == 0) ending = END_SEEK_RANGE;
        if (ending == END_DIFF_RANGE) nsz = g_pos + $urandom_range(0, 5);
        if (ending == END_POS_PAST_SIZE) nsz = g_pos - 1;
      end
      if (nsz > 64'hFFFF_FFFF) nsz = 64'hFFFF_FFFF;
      cfg_write(CFG_OLD_IMAGE_SIZE, {$urandom, nsz[31:0]});
      g_size = nsz;
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_MAGIC_WORD, {$urandom, $urandom});
    end while (plan.size() != 0);

    case (ending)
      END_OK, END_SIZE_MISMATCH: begin
        repeat (3) queue_word('0);
      end
      END_CUT_HEADER: begin
        repeat ($urandom_range(0, 23)) queue_byte($urandom_range(0, 255));
        queue_item($urandom_range(0, 255), 1'b1, $urandom_range(0, 255));
      end
      END_CUT_EXTRA: begin
        queue_word('0);
        queue_word('1);
        queue_word('0);
        repeat ($urandom_range(1, 6)) queue_byte($urandom_range(0, 255));
        queue_item($urandom_range(0, 255), 1'b1, $urandom_range(0, 255));
      end
      END_DIFF_RANGE: begin
        queue_word('1);
        queue_word('0);
        queue_word('0);
        repeat (g_size - g_pos + 1) queue_byte($urandom_range(0, 255));
      end
      END_SEEK_RANGE: begin
        k = $urandom_range(0, 3);
        if (k == 0) seek = -(g_pos + 1);
        else if (k == 1) seek = g_size - g_pos + 1;
        else if (k == 2) seek = 64'h8000_0000_0000_0000;
        else seek = 64'h7FFF_FFFF_FFFF_FFFF;
        queue_word('0);
        queue_word('0);
        queue_word(seek);
      end
      default: begin
        // position now lies past the shrunken image: fails at the seek
        queue_word('0);
        queue_word(64'd1);
        queue_word('0);
        queue_byte($urandom_range(0, 255));
      end
    endcase

    // the block is finished now: everything after must be ignored
    repeat (20) queue_item($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 255));

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
